// ===== src/gf128_multiply_power_inverse_defines.svh =====
// Assertion macros shared by the GF(2^128) arithmetic unit
`ifndef GF128_MULTIPLY_POWER_INVERSE_DEFINES_SVH
`define GF128_MULTIPLY_POWER_INVERSE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define GFMPI_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GFMPI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gfmpi_pkg.sv =====
// Shared types and constants of the GF(2^128) arithmetic unit
`timescale 1ns / 1ps

package gfmpi_pkg;

  // Field element width and bits of b consumed per multiplier cycle
  localparam int ELEM_W     = 128;
  localparam int DIGIT_W    = 16;
  localparam int NUM_DIGITS = ELEM_W / DIGIT_W;

  // Default exponent width and squarings needed for an inverse
  localparam int EXP_BITS_DEF = 32;
  localparam int INV_ITERS    = 127;

  // Multiplicative identity
  localparam logic [ELEM_W-1:0] ELEM_ONE = ELEM_W'(1);

  // Operation codes
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_POW = 2'd1,
    OP_INV = 2'd2
  } op_t;

  // Status of the shared multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// ===== src/gfmpi_mul.sv =====
// Digit-serial GF(2^128) multiplier, modulo x^128 + x^7 + x^2 + x + 1
`timescale 1ns / 1ps
`include "gf128_multiply_power_inverse_defines.svh"

module gfmpi_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [gfmpi_pkg::ELEM_W-1:0]       op_a,
  input  logic [gfmpi_pkg::ELEM_W-1:0]       op_b,
  output gfmpi_pkg::mul_stat_t               stat,
  output logic [gfmpi_pkg::ELEM_W-1:0]       res
);

  localparam int EW    = gfmpi_pkg::ELEM_W;
  localparam int DW    = gfmpi_pkg::DIGIT_W;
  localparam int CNT_W = $clog2(gfmpi_pkg::NUM_DIGITS);

  logic [EW-1:0]    a_r, a_nxt;
  logic [EW-1:0]    b_r, b_nxt;
  logic [EW-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DW-1:0]    digit;
  logic [EW+DW-1:0] prod;
  logic [EW+DW-1:0] wide;
  logic [DW-1:0]    ovf;
  logic [EW-1:0]    ovf_ext;
  logic [EW-1:0]    step;

  // Carry-less product of a with the top digit of b
  always_comb begin
    digit = b_r[EW-1 -: DW];
    prod  = '0;
    for (int j = 0; j < DW; j++) begin
      if (digit[j]) begin
        prod = prod ^ ({{DW{1'b0}}, a_r} << j);
      end
    end
  end

  // Shift accumulator one digit, add product, fold overflow with x^7+x^2+x+1
  always_comb begin
    wide    = {acc_r, {DW{1'b0}}} ^ prod;
    ovf     = wide[EW+DW-1 -: DW];
    ovf_ext = EW'(ovf);
    step    = wide[EW-1:0] ^ ovf_ext ^ (ovf_ext << 1) ^ (ovf_ext << 2) ^ (ovf_ext << 7);
  end

  // Sequence the digits
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = op_a;
      b_nxt    = op_b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = step;
      b_nxt   = b_r << DW;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(gfmpi_pkg::NUM_DIGITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and accumulator registers
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = acc_r;

  `GFMPI_ASSERT_IMPLY(a_no_restart, clk, rst_n, start, !busy_r, "multiplier restarted while busy")
  `GFMPI_ASSERT_NEXT(a_done_ends_run, clk, rst_n, done_r && !start, !busy_r && !done_r, "multiplier done not a single pulse")

endmodule

// ===== src/gf128_multiply_power_inverse.sv =====
// Top level: GF(2^128) multiply, power and inverse over one shared multiplier
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in_     | input     | in_valid / in_stall  | op, a_lo, a_hi, b_lo, b_hi, exponent
//   out_    | output    | out_valid / out_stall| res_lo, res_hi
//
// Every field product goes through one digit-serial multiplier, 16 bits of b per
// cycle. Multiply is one product; power is one squaring per exponent bit plus one
// multiply per set bit (EXP_BITS bits); inverse is 254 products. An unused op
// returns zero without using the multiplier.
// Reset is synchronous and active low; it clears the control registers of the sequencer and multiplier only.
// One transaction is in flight at a time; in_stall stays high until the result
// transaction is taken, and out_stall holds the result in place.
`timescale 1ns / 1ps
`include "gf128_multiply_power_inverse_defines.svh"

module gf128_multiply_power_inverse #(
  parameter int EXP_BITS = gfmpi_pkg::EXP_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_a_lo,
  input  logic [63:0] in_a_hi,
  input  logic [63:0] in_b_lo,
  input  logic [63:0] in_b_hi,
  input  logic [31:0] in_exponent,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_res_lo,
  output logic [63:0] out_res_hi
);

  localparam int EW     = gfmpi_pkg::ELEM_W;
  localparam int MAX_IT = (EXP_BITS > gfmpi_pkg::INV_ITERS) ? EXP_BITS : gfmpi_pkg::INV_ITERS;
  localparam int CNT_W  = $clog2(MAX_IT + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                mu_phase_r, mu_phase_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [EW-1:0]       a_r, a_nxt;
  logic [EW-1:0]       b_r, b_nxt;
  logic [EW-1:0]       x_r, x_nxt;
  logic [EXP_BITS-1:0] e_r, e_nxt;
  logic                iter_end;

  logic                 mul_start;
  logic [EW-1:0]        mul_a;
  logic [EW-1:0]        mul_b;
  logic [EW-1:0]        mul_res;
  gfmpi_pkg::mul_stat_t mul_stat;

  // Pick multiplier operands; for inverse b_r holds the running square
  always_comb begin
    case (op_r)
      gfmpi_pkg::OP_MUL: begin
        mul_a = a_r;
        mul_b = b_r;
      end
      gfmpi_pkg::OP_INV: begin
        mul_a = mu_phase_r ? x_r : b_r;
        mul_b = b_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = mu_phase_r ? a_r : x_r;
      end
    endcase
  end

  gfmpi_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .stat  (mul_stat),
    .res   (mul_res)
  );

  // Sequencer: per iteration square, then multiply (power: only on a set exponent bit); multiply op is one product
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    mu_phase_nxt = mu_phase_r;
    op_nxt       = op_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    x_nxt        = x_r;
    e_nxt        = e_r;
    mul_start    = 1'b0;
    iter_end     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_op;
          a_nxt        = {in_a_hi, in_a_lo};
          b_nxt        = (in_op == gfmpi_pkg::OP_INV) ? {in_a_hi, in_a_lo} : {in_b_hi, in_b_lo};
          e_nxt        = EXP_BITS'(in_exponent);
          mu_phase_nxt = 1'b0;
          x_nxt        = gfmpi_pkg::ELEM_ONE;
          state_nxt    = S_ISSUE;
          case (in_op)
            gfmpi_pkg::OP_POW: cnt_nxt = CNT_W'(EXP_BITS);
            gfmpi_pkg::OP_INV: cnt_nxt = CNT_W'(gfmpi_pkg::INV_ITERS);
            gfmpi_pkg::OP_MUL: cnt_nxt = CNT_W'(1);
            default: begin
              cnt_nxt   = CNT_W'(1);
              x_nxt     = '0;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_ISSUE: begin
        mul_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (mul_stat.done) begin
          case (op_r)
            gfmpi_pkg::OP_MUL: begin
              x_nxt     = mul_res;
              state_nxt = S_OUT;
            end
            gfmpi_pkg::OP_POW: begin
              x_nxt = mul_res;
              if (!mu_phase_r && e_r[EXP_BITS-1]) begin
                mu_phase_nxt = 1'b1;
                state_nxt    = S_ISSUE;
              end else begin
                iter_end = 1'b1;
              end
            end
            gfmpi_pkg::OP_INV: begin
              if (!mu_phase_r) begin
                b_nxt        = mul_res;
                mu_phase_nxt = 1'b1;
                state_nxt    = S_ISSUE;
              end else begin
                x_nxt    = mul_res;
                iter_end = 1'b1;
              end
            end
            default: state_nxt = S_OUT;
          endcase
          // Advance to the next exponent bit or iteration, or finish
          if (iter_end) begin
            e_nxt        = e_r << 1;
            cnt_nxt      = cnt_r - CNT_W'(1);
            mu_phase_nxt = 1'b0;
            state_nxt    = (cnt_r == CNT_W'(1)) ? S_OUT : S_ISSUE;
          end
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      mu_phase_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      mu_phase_r <= mu_phase_nxt;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    x_r  <= x_nxt;
    e_r  <= e_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign out_res_lo = x_r[63:0];
  assign out_res_hi = x_r[EW-1:64];

  `GFMPI_ASSERT_IMPLY(a_done_in_wait, clk, rst_n, mul_stat.done, state_r == S_WAIT, "multiplier finished outside the wait state")
  `GFMPI_ASSERT_NEXT(a_issue_starts, clk, rst_n, state_r == S_ISSUE, mul_stat.busy, "issued product did not start")
  `GFMPI_ASSERT_IMPLY(a_cnt_live, clk, rst_n, state_r == S_ISSUE || state_r == S_WAIT, cnt_r != '0, "iteration count ran out while working")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the GF(2^128) multiply, power and inverse unit
`timescale 1ns / 1ps

module tb_top;

  localparam int EW = gfmpi_pkg::ELEM_W;

  // x^128 folds back as x^7 + x^2 + x + 1
  localparam logic [EW-1:0] FOLD_POLY  = 128'h87;
  localparam logic [EW-1:0] ALL_ONES   = {EW{1'b1}};
  localparam logic [EW-1:0] ELEM_X     = 128'h2;
  localparam logic [EW-1:0] ELEM_X127  = {1'b1, 127'b0};
  localparam logic [1:0]    OP_SPARE   = 2'd3;
  localparam int            MAX_REPORTS = 10;
  localparam int            HOLD_CYCLES = 400;
  localparam int            TAIL_CYCLES = 20;
  localparam longint        TIMEOUT_NS  = 30_000_000;

  typedef struct {
    logic [1:0]    op;
    logic [EW-1:0] a;
    logic [EW-1:0] value;
  } elem_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [63:0] in_a_lo;
  logic [63:0] in_a_hi;
  logic [63:0] in_b_lo;
  logic [63:0] in_b_hi;
  logic [31:0] in_exponent;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_res_lo;
  logic [63:0] out_res_hi;

  elem_result_t expected_elems[$];
  int  fail_count = 0;
  int  mismatch_count = 0;
  int  results_checked = 0;
  int  sent_per_op[4] = '{0, 0, 0, 0};
  bit  tx_no_gaps = 1'b0;
  bit  rx_stall_en = 1'b1;
  int  rx_hold_cycles = 0;

  gf128_multiply_power_inverse dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_a_lo    (in_a_lo),
    .in_a_hi    (in_a_hi),
    .in_b_lo    (in_b_lo),
    .in_b_hi    (in_b_hi),
    .in_exponent(in_exponent),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res_lo (out_res_lo),
    .out_res_hi (out_res_hi)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // Field arithmetic: shift-and-add product, reduced one bit at a time
  function automatic logic [EW-1:0] field_mul(input logic [EW-1:0] x,
                                              input logic [EW-1:0] y);
    logic [EW-1:0] acc;
    acc = '0;
    for (int i = EW - 1; i >= 0; i--) begin
      acc = {acc[EW-2:0], 1'b0} ^ (acc[EW-1] ? FOLD_POLY : '0);
      if (y[i]) acc ^= x;
    end
    return acc;
  endfunction

  // Square-and-multiply over every exponent bit, top bit first
  function automatic logic [EW-1:0] field_pow(input logic [EW-1:0] base,
                                              input logic [31:0] e);
    logic [EW-1:0] acc;
    acc = gfmpi_pkg::ELEM_ONE;
    for (int i = gfmpi_pkg::EXP_BITS_DEF - 1; i >= 0; i--) begin
      acc = field_mul(acc, acc);
      if (e[i]) acc = field_mul(acc, base);
    end
    return acc;
  endfunction

  // a^(2^128-2) as the product of a^(2^i), i = 1..127; zero stays zero
  function automatic logic [EW-1:0] field_inv(input logic [EW-1:0] base);
    logic [EW-1:0] sq;
    logic [EW-1:0] acc;
    sq  = base;
    acc = gfmpi_pkg::ELEM_ONE;
    for (int i = 0; i < gfmpi_pkg::INV_ITERS; i++) begin
      sq  = field_mul(sq, sq);
      acc = field_mul(acc, sq);
    end
    return acc;
  endfunction

  function automatic logic [EW-1:0] field_result(input logic [1:0] op,
                                                 input logic [EW-1:0] a,
                                                 input logic [EW-1:0] b,
                                                 input logic [31:0] e);
    case (op)
      gfmpi_pkg::OP_MUL: return field_mul(a, b);
      gfmpi_pkg::OP_POW: return field_pow(a, e);
      gfmpi_pkg::OP_INV: return field_inv(a);
      default:           return '0;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Operand shapes: zero, all ones, one, single bit, one half only, dense
  function automatic logic [EW-1:0] rand_elem();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return gfmpi_pkg::ELEM_ONE;
      3:       return gfmpi_pkg::ELEM_ONE << $urandom_range(0, EW - 1);
      4:       return {64'b0, rand64()};
      5:       return {rand64(), 64'b0};
      default: return {rand64(), rand64()};
    endcase
  endfunction

  function automatic logic [31:0] rand_exponent();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(1, 16);
      3:       return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Offer one transaction, hold it until taken, then record its expected result
  task automatic send_item(input logic [1:0] op, input logic [EW-1:0] a,
                           input logic [EW-1:0] b, input logic [31:0] e);
    int gap;
    bit took;
    gap = tx_no_gaps ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_a_lo     <= a[63:0];
    in_a_hi     <= a[127:64];
    in_b_lo     <= b[63:0];
    in_b_hi     <= b[127:64];
    in_exponent <= e;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    expected_elems.push_back('{op: op, a: a, value: field_result(op, a, b, e)});
    sent_per_op[op]++;
  endtask

  // Drop valid and wait until every outstanding result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_elems.size() != 0);
  endtask

  task automatic send_random_item();
    int pick;
    logic [1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 55)      op = gfmpi_pkg::OP_MUL;
    else if (pick < 85) op = gfmpi_pkg::OP_POW;
    else if (pick < 93) op = gfmpi_pkg::OP_INV;
    else                op = OP_SPARE;
    send_item(op, rand_elem(), rand_elem(), rand_exponent());
  endtask

  task automatic test_multiply_directed();
    send_item(gfmpi_pkg::OP_MUL, '0, {rand64(), rand64()}, $urandom);
    send_item(gfmpi_pkg::OP_MUL, gfmpi_pkg::ELEM_ONE, {rand64(), rand64()}, $urandom);
    send_item(gfmpi_pkg::OP_MUL, {rand64(), rand64()}, gfmpi_pkg::ELEM_ONE, $urandom);
    send_item(gfmpi_pkg::OP_MUL, ALL_ONES, ALL_ONES, '1);
    send_item(gfmpi_pkg::OP_MUL, ELEM_X127, ELEM_X, '0);
    send_item(gfmpi_pkg::OP_MUL, ELEM_X127, ELEM_X127, $urandom);
    send_item(gfmpi_pkg::OP_MUL, {rand64(), 64'b0}, {64'b0, rand64()}, $urandom);
    send_item(gfmpi_pkg::OP_MUL, {rand64(), rand64()}, {rand64(), rand64()}, $urandom);
  endtask

  task automatic test_power_directed();
    send_item(gfmpi_pkg::OP_POW, '0, {rand64(), rand64()}, '0);
    send_item(gfmpi_pkg::OP_POW, {rand64(), rand64()}, ALL_ONES, '0);
    send_item(gfmpi_pkg::OP_POW, {rand64(), rand64()}, {rand64(), rand64()}, 32'd1);
    send_item(gfmpi_pkg::OP_POW, {rand64(), rand64()}, '0, 32'd2);
    send_item(gfmpi_pkg::OP_POW, {rand64(), rand64()}, {rand64(), rand64()}, '1);
    send_item(gfmpi_pkg::OP_POW, '0, ALL_ONES, 32'd7);
    send_item(gfmpi_pkg::OP_POW, ELEM_X, '0, 32'd128);
    send_item(gfmpi_pkg::OP_POW, ALL_ONES, {rand64(), rand64()}, 32'h8000_0000);
  endtask

  task automatic test_inverse_directed();
    send_item(gfmpi_pkg::OP_INV, '0, {rand64(), rand64()}, $urandom);
    send_item(gfmpi_pkg::OP_INV, gfmpi_pkg::ELEM_ONE, ALL_ONES, '1);
    send_item(gfmpi_pkg::OP_INV, ELEM_X, '0, '0);
    send_item(gfmpi_pkg::OP_INV, ALL_ONES, {rand64(), rand64()}, $urandom);
    send_item(gfmpi_pkg::OP_INV, {rand64(), rand64()}, {rand64(), rand64()}, $urandom);
  endtask

  task automatic test_spare_opcode();
    send_item(OP_SPARE, {rand64(), rand64()}, {rand64(), rand64()}, $urandom);
    send_item(OP_SPARE, ALL_ONES, ALL_ONES, '1);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    tx_no_gaps = 1'b1;
    rx_hold_cycles = HOLD_CYCLES;
    repeat (6) send_item(gfmpi_pkg::OP_MUL, rand_elem(), rand_elem(), $urandom);
    tx_no_gaps = 1'b0;
  endtask

  // Sender stops and waits for the block to empty before going on
  task automatic test_sender_pause();
    repeat (3) send_random_item();
    drain_results();
    repeat (3) send_random_item();
  endtask

  // Back-to-back traffic with no sender gaps and no receiver stalls
  task automatic test_full_rate_stretch();
    tx_no_gaps  = 1'b1;
    rx_stall_en = 1'b0;
    repeat (30) send_item(gfmpi_pkg::OP_MUL, rand_elem(), rand_elem(), rand_exponent());
    repeat (5) send_item(gfmpi_pkg::OP_POW, rand_elem(), rand_elem(), rand_exponent());
    tx_no_gaps  = 1'b0;
    rx_stall_en = 1'b1;
  endtask

  // Mixed random traffic, with idle behavior reshuffled every few dozen items
  task automatic test_random_mix(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        tx_no_gaps  = ($urandom_range(0, 3) == 0);
        rx_stall_en = ($urandom_range(0, 3) != 0);
      end
      send_random_item();
    end
    tx_no_gaps  = 1'b0;
    rx_stall_en = 1'b1;
  endtask

  // Result receiver: stall for a drawn or requested number of cycles once a result shows up
  initial begin : result_receiver
    int hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_cycles > 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        hold = rx_stall_en ? $urandom_range(0, 19) : 0;
      end
      out_stall <= (hold != 0);
      do @(negedge clk); while (!out_valid);
      if (hold != 0) begin
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
        @(negedge clk);
      end
      @(posedge clk);
    end
  end

  // Compare every taken result with the oldest expectation
  always @(negedge clk) begin : check_results
    elem_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_elems.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result %h_%h with nothing outstanding", out_res_hi, out_res_lo);
      end else begin
        want = expected_elems.pop_front();
        results_checked++;
        if (out_res_lo !== want.value[63:0] || out_res_hi !== want.value[127:64]) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch op %0d a %h: expected %h_%h got %h_%h", want.op, want.a,
                     want.value[127:64], want.value[63:0], out_res_hi, out_res_lo);
        end
      end
    end
  end

  // Reset, run the tests in turn, then settle and report
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_op       <= gfmpi_pkg::OP_MUL;
    in_a_lo     <= '0;
    in_a_hi     <= '0;
    in_b_lo     <= '0;
    in_b_hi     <= '0;
    in_exponent <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_multiply_directed();
    test_power_directed();
    test_inverse_directed();
    test_spare_opcode();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate_stretch();
    test_random_mix(460);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    fail_count += expected_elems.size();

    $display("Covered %0d multiply, %0d power, %0d inverse and %0d spare-opcode transactions",
             sent_per_op[gfmpi_pkg::OP_MUL], sent_per_op[gfmpi_pkg::OP_POW],
             sent_per_op[gfmpi_pkg::OP_INV], sent_per_op[OP_SPARE]);
    $display("under random idling, a long output hold-off and a full drain; %0d results checked",
             results_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
